// File: src/nss_pkg.sv
// shared types and constants of the nearest site search unit
package nss_pkg;

    localparam int COORD_W    = 16;
    localparam int SQ_W       = 32;
    localparam int DIST_W     = 33;
    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 4;

    localparam logic [DIST_W-1:0] RADIUS_RESET = 33'd100000000;

    localparam logic REG_MAX_DISTANCE_SQ = 1'b0;

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_TIE  = 2'd1;
    localparam logic [1:0] ST_NONE = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    typedef struct packed {
        logic [1:0]                command;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic [7:0]                exclude_first;
        logic                      exclude_first_on;
        logic [7:0]                exclude_second;
        logic                      exclude_second_on;
    } t_nss_in;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] site_index;
        logic [8:0] site_count;
    } t_nss_out;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } t_site;

endpackage

// File: src/nss_site_mem.sv
// site coordinate memory, one write port and one registered read port
module nss_site_mem #(
    parameter int DEPTH = 256,
    parameter int ADDR_W = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  nss_pkg::t_site    i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output nss_pkg::t_site    o_rdata
);
    import nss_pkg::*;

    t_site r_mem [DEPTH];
    t_site r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/nss_dist_unit.sv
// pipelined squared distance unit shared by every site of a scan
module nss_dist_unit #(
    parameter int IDX_W = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  logic [IDX_W-1:0]                   i_index,
    input  nss_pkg::t_site                     i_site,
    input  logic signed [nss_pkg::COORD_W-1:0] i_qx,
    input  logic signed [nss_pkg::COORD_W-1:0] i_qy,
    output logic                               o_valid,
    output logic [IDX_W-1:0]                   o_index,
    output logic [nss_pkg::DIST_W-1:0]         o_dist
);
    import nss_pkg::*;

    logic signed [COORD_W:0] dx;
    logic signed [COORD_W:0] dy;
    logic [COORD_W:0]        ndx;
    logic [COORD_W:0]        ndy;

    logic [2:0]         r_valid;
    logic [IDX_W-1:0]   r_idx0;
    logic [IDX_W-1:0]   r_idx1;
    logic [IDX_W-1:0]   r_idx2;
    logic [COORD_W-1:0] r_ax;
    logic [COORD_W-1:0] r_ay;
    logic [SQ_W-1:0]    r_sx;
    logic [SQ_W-1:0]    r_sy;
    logic [DIST_W-1:0]  r_dist;

    always_comb begin
        dx  = (COORD_W+1)'(i_site.x) - (COORD_W+1)'(i_qx);
        dy  = (COORD_W+1)'(i_site.y) - (COORD_W+1)'(i_qy);
        ndx = dx[COORD_W] ? (COORD_W+1)'(-dx) : dx;
        ndy = dy[COORD_W] ? (COORD_W+1)'(-dy) : dy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[1:0], i_valid};
        end
        // magnitudes
        r_ax   <= ndx[COORD_W-1:0];
        r_ay   <= ndy[COORD_W-1:0];
        r_idx0 <= i_index;
        // squares
        r_sx   <= SQ_W'(r_ax) * SQ_W'(r_ax);
        r_sy   <= SQ_W'(r_ay) * SQ_W'(r_ay);
        r_idx1 <= r_idx0;
        // sum
        r_dist <= DIST_W'(r_sx) + DIST_W'(r_sy);
        r_idx2 <= r_idx1;
    end

    assign o_valid = r_valid[2];
    assign o_index = r_idx2;
    assign o_dist  = r_dist;

endmodule

// File: src/nearest_site_search_unit.sv
// nearest site search unit: command sequencer, site table, radius register
// add, clear and the unused command: result strobe in the cycle after the start beat, busy stays low
// query: scan (skipped for an empty table), drain and finish states, then the result strobe, busy meanwhile
// the scan reads one site a cycle; add and clear beats can follow every cycle
// reset is synchronous: count cleared, radius back to 100000000, site memory not cleared
// results are strobed for one cycle; the receiver cannot stall
module nearest_site_search_unit #(
    parameter int MAX_SITES = 256
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  nss_pkg::t_nss_in                     i_cmd,
    output logic                                 o_done,
    output nss_pkg::t_nss_out                    o_result,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [nss_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [nss_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [nss_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                 pready
);
    import nss_pkg::*;

    localparam int IDX_W = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
    localparam int CNT_W = $clog2(MAX_SITES + 1);
    localparam int CMP_W = (IDX_W > 8) ? IDX_W : 8;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_FINISH} t_state;

    t_state            r_state;
    logic [CNT_W-1:0]  r_count;
    logic [DIST_W-1:0] r_radius;
    logic [IDX_W-1:0]  r_idx;
    logic [1:0]        r_drain;
    t_nss_in           r_q;
    logic              r_mvalid;
    logic [IDX_W-1:0]  r_midx;
    logic [1:0]        r_hits;
    logic [DIST_W-1:0] r_best;
    logic [IDX_W-1:0]  r_found;
    logic              r_done;
    t_nss_out          r_result;

    logic              accept;
    logic              full;
    logic              mem_we;
    t_site             wsite;
    t_site             rsite;
    logic              excluded;
    logic              issue;
    logic              last_idx;
    logic              cfg_write;
    logic              d_valid;
    logic [IDX_W-1:0]  d_index;
    logic [DIST_W-1:0] d_dist;
    logic              in_radius;
    logic              better;

    assign accept    = start && !busy;
    assign full      = (r_count >= CNT_W'(MAX_SITES));
    assign mem_we    = accept && (i_cmd.command == CMD_ADD) && !full;
    assign wsite.x   = i_cmd.coord_x;
    assign wsite.y   = i_cmd.coord_y;
    assign cfg_write = psel && penable && pwrite && pready;

    assign excluded = (r_q.exclude_first_on && (CMP_W'(r_idx) == CMP_W'(r_q.exclude_first)))
                   || (r_q.exclude_second_on && (CMP_W'(r_idx) == CMP_W'(r_q.exclude_second)));
    assign issue    = (r_state == S_SCAN) && !excluded;
    assign last_idx = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);

    assign in_radius = d_dist < r_radius;
    assign better    = (r_hits == 2'd0) || (d_dist < r_best);

    nss_site_mem #(
        .DEPTH  (MAX_SITES),
        .ADDR_W (IDX_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (wsite),
        .i_raddr (r_idx),
        .o_rdata (rsite)
    );

    nss_dist_unit #(
        .IDX_W (IDX_W)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_mvalid),
        .i_index (r_midx),
        .i_site  (rsite),
        .i_qx    (r_q.coord_x),
        .i_qy    (r_q.coord_y),
        .o_valid (d_valid),
        .o_index (d_index),
        .o_dist  (d_dist)
    );

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RESET;
        end else if (cfg_write && (paddr[3] == REG_MAX_DISTANCE_SQ)) begin
            r_radius <= pwdata[DIST_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[3] == REG_MAX_DISTANCE_SQ) ? APB_DATA_W'(r_radius) : '0;

    // sequencer, tracker and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_idx    <= '0;
            r_drain  <= '0;
            r_mvalid <= 1'b0;
            r_hits   <= '0;
            r_done   <= 1'b0;
        end else begin
            r_done   <= (r_state == S_FINISH) || (accept && (i_cmd.command != CMD_QUERY));
            r_mvalid <= issue;
            r_midx   <= r_idx;
            if (d_valid && in_radius) begin
                if (better) begin
                    r_best  <= d_dist;
                    r_found <= d_index;
                    r_hits  <= 2'd1;
                end else if (d_dist == r_best) begin
                    r_hits <= 2'd2;
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        case (i_cmd.command)
                            CMD_ADD: begin
                                r_result.site_index <= '0;
                                if (full) begin
                                    r_result.status     <= ST_FULL;
                                    r_result.site_count <= 9'(r_count);
                                end else begin
                                    r_result.status     <= ST_OK;
                                    r_count             <= r_count + CNT_W'(1);
                                    r_result.site_count <= 9'(r_count + CNT_W'(1));
                                end
                            end
                            CMD_CLEAR: begin
                                r_count             <= '0;
                                r_result.status     <= ST_OK;
                                r_result.site_index <= '0;
                                r_result.site_count <= '0;
                            end
                            CMD_QUERY: begin
                                r_q     <= i_cmd;
                                r_idx   <= '0;
                                r_drain <= '0;
                                r_hits  <= '0;
                                r_state <= (r_count == '0) ? S_DRAIN : S_SCAN;
                            end
                            default: begin
                                r_result.status     <= ST_OK;
                                r_result.site_index <= '0;
                                r_result.site_count <= 9'(r_count);
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (last_idx) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_idx <= r_idx + IDX_W'(1);
                    end
                end
                S_DRAIN: begin
                    r_drain <= r_drain + 2'd1;
                    if (r_drain == 2'd3) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    r_result.site_count <= 9'(r_count);
                    if (r_hits == 2'd0) begin
                        r_result.status     <= ST_NONE;
                        r_result.site_index <= '0;
                    end else if (r_hits == 2'd1) begin
                        r_result.status     <= ST_OK;
                        r_result.site_index <= 8'(r_found);
                    end else begin
                        r_result.status     <= ST_TIE;
                        r_result.site_index <= '0;
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// File: verif/nss_result_checker.sv
// result checker of the nearest site search unit: predicts and checks every result beat
module nss_result_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    input  logic                           busy,
    input  nss_pkg::t_nss_in               i_cmd,
    input  logic                           o_done,
    input  nss_pkg::t_nss_out              o_result,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic                           pready,
    input  logic [nss_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [nss_pkg::APB_DATA_W-1:0] pwdata,
    output int                             o_pending,
    output int                             o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import nss_pkg::*;

    localparam int TABLE_DEPTH = 256;
    localparam logic [APB_ADDR_W-1:0] RADIUS_ADDR = {REG_MAX_DISTANCE_SQ, 3'b000};

    logic signed [COORD_W-1:0] site_x [TABLE_DEPTH];
    logic signed [COORD_W-1:0] site_y [TABLE_DEPTH];
    int unsigned               site_total = 0;
    logic [DIST_W-1:0]         radius_sq = RADIUS_RESET;
    t_nss_out                  awaited_replies [$];
    int                        fails = 0;

    function automatic t_nss_out answer_command(t_nss_in it);
        t_nss_out r;
        longint   dx;
        longint   dy;
        longint   sq_len;
        longint   best;
        int       hits;
        int       i;
        r = '0;
        hits = 0;
        best = 0;
        case (it.command)
            CMD_ADD: begin
                if (site_total >= TABLE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    site_x[site_total] = it.coord_x;
                    site_y[site_total] = it.coord_y;
                    site_total++;
                end
            end
            CMD_CLEAR: begin
                site_total = 0;
            end
            CMD_QUERY: begin
                for (i = 0; i < site_total; i++) begin
                    if (it.exclude_first_on && i == it.exclude_first) continue;
                    if (it.exclude_second_on && i == it.exclude_second) continue;
                    dx = longint'(site_x[i]) - longint'(it.coord_x);
                    dy = longint'(site_y[i]) - longint'(it.coord_y);
                    sq_len = dx * dx + dy * dy;
                    if (sq_len >= longint'(radius_sq)) continue;
                    if (hits == 0 || sq_len < best) begin
                        best = sq_len;
                        r.site_index = i[7:0];
                        hits = 1;
                    end else if (sq_len == best) begin
                        hits++;
                    end
                end
                if (hits == 0) begin
                    r.status = ST_NONE;
                    r.site_index = '0;
                end else if (hits > 1) begin
                    r.status = ST_TIE;
                    r.site_index = '0;
                end
            end
            default: ;
        endcase
        r.site_count = site_total[8:0];
        return r;
    endfunction

    task automatic check_field(string label, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_nss_out want;
        t_nss_out fresh;
        if (!i_rst_n) begin
            site_total = 0;
            radius_sq = RADIUS_RESET;
            awaited_replies.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == RADIUS_ADDR) begin
                radius_sq = pwdata[DIST_W-1:0];
            end
            if (o_done) begin
                if (awaited_replies.size() == 0) begin
                    $display("%0t: result beat with nothing expected, %s %0d index %0d count %0d",
                             $time, "actual status", o_result.status,
                             o_result.site_index, o_result.site_count);
                    fails++;
                end else begin
                    want = awaited_replies.pop_front();
                    check_field("status", want.status, o_result.status);
                    check_field("site_index", want.site_index, o_result.site_index);
                    check_field("site_count", want.site_count, o_result.site_count);
                end
            end
            if (start && !busy) begin
                fresh = answer_command(i_cmd);
                awaited_replies = {awaited_replies, fresh};
            end
        end
        o_pending <= awaited_replies.size();
        o_fail_count <= fails;
    end

endmodule

// File: verif/nearest_site_search_unit_tb.sv
// testbench top of the nearest site search unit: command and register stimulus, watchdog, verdict
module nearest_site_search_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import nss_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int ITEM_TARGET = 1350;
    localparam int PHASE_ITEMS = 150;
    localparam int QUIET_LIMIT = 3000;
    localparam int TABLE_DEPTH = 256;
    localparam logic [APB_ADDR_W-1:0] RADIUS_ADDR = {REG_MAX_DISTANCE_SQ, 3'b000};
    localparam logic [DIST_W-1:0] RADIUS_FULL = '1;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    t_nss_in               i_cmd;
    logic                  o_done;
    t_nss_out              o_result;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    int                    pending;
    int                    fail_count;
    int                    quiet = 0;
    int                    items_sent = 0;
    int                    sites_held = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    nearest_site_search_unit DUT (.*);

    nss_result_checker checker_inst (
        .i_clk, .i_rst_n, .start, .busy, .i_cmd, .o_done, .o_result,
        .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
        .o_pending(pending), .o_fail_count(fail_count)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    function automatic int pick_gap(bit burst);
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_nss_in random_item();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[$bits(t_nss_in)-1:0];
    endfunction

    function automatic t_nss_in mk_item(logic [1:0] cmd, int x, int y,
                                        int e1, bit e1_on, int e2, bit e2_on);
        t_nss_in it;
        it.command = cmd;
        it.coord_x = 16'(x);
        it.coord_y = 16'(y);
        it.exclude_first = 8'(e1);
        it.exclude_first_on = e1_on;
        it.exclude_second = 8'(e2);
        it.exclude_second_on = e2_on;
        return it;
    endfunction

    function automatic logic signed [COORD_W-1:0] near_coord(int centre, bit wide);
        if (wide) begin
            if ($urandom_range(0, 15) == 0) return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            return 16'($urandom);
        end
        return 16'(centre + int'($urandom_range(0, 12)) - 6);
    endfunction

    function automatic t_nss_in with_exclusions(t_nss_in it, int held);
        int top_idx;
        top_idx = held > 255 ? 255 : held;
        it.exclude_first_on = $urandom_range(0, 3) != 0;
        it.exclude_second_on = $urandom_range(0, 2) != 0;
        it.exclude_first = $urandom_range(0, 3) == 0 ? 8'($urandom)
                                                     : 8'($urandom_range(0, top_idx));
        it.exclude_second = $urandom_range(0, 3) == 0 ? 8'($urandom)
                                                      : 8'($urandom_range(0, top_idx));
        if ($urandom_range(0, 5) == 0) it.exclude_second = it.exclude_first;
        return it;
    endfunction

    task automatic send_item(t_nss_in it, int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= it;
        do @(posedge i_clk); while (busy);
        items_sent++;
        if (it.command == CMD_ADD && sites_held < TABLE_DEPTH) sites_held++;
        if (it.command == CMD_CLEAR) sites_held = 0;
    endtask

    task automatic drain_results(int settle);
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_radius(logic [DIST_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= RADIUS_ADDR;
        pwdata <= {31'($urandom), value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic logic [DIST_W-1:0] radius_for(int phase);
        case (phase % 8)
            0: return RADIUS_FULL;
            1: return '0;
            2: return 33'd1;
            3: return 33'd50;
            4: return RADIUS_RESET;
            5: return 33'h1_0000_0000;
            6: return 33'($urandom_range(2, 600));
            default: return {1'($urandom), $urandom};
        endcase
    endfunction

    task automatic run_episode(bit fill);
        int      n_sites;
        int      n_queries;
        int      cx;
        int      cy;
        int      i;
        bit      wide;
        bit      burst;
        t_nss_in it;
        burst = $urandom_range(0, 4) == 0;
        wide = $urandom_range(0, 3) == 0;
        cx = int'($urandom_range(0, 400)) - 200;
        cy = int'($urandom_range(0, 400)) - 200;
        if (fill || sites_held > 40 || $urandom_range(0, 3) != 0) begin
            it = random_item();
            it.command = CMD_CLEAR;
            send_item(it, pick_gap(burst));
        end
        if (fill) n_sites = TABLE_DEPTH + 3;
        else if ($urandom_range(0, 11) == 0) n_sites = 0;
        else n_sites = $urandom_range(1, 14);
        for (i = 0; i < n_sites; i++) begin
            it = random_item();
            it.command = CMD_ADD;
            it.coord_x = near_coord(cx, wide);
            it.coord_y = near_coord(cy, wide);
            send_item(it, pick_gap(burst));
        end
        if ($urandom_range(0, 9) == 0) drain_results(0);
        n_queries = $urandom_range(2, 9);
        for (i = 0; i < n_queries; i++) begin
            it = random_item();
            if ($urandom_range(0, 14) != 0) begin
                it.command = CMD_QUERY;
                it.coord_x = near_coord(cx, wide);
                it.coord_y = near_coord(cy, wide);
                it = with_exclusions(it, sites_held);
            end
            send_item(it, pick_gap(burst));
        end
    endtask

    initial begin
        int phase;
        int phase_start;
        start <= 1'b0;
        i_cmd <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        i_rst_n <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table, extremes, exclusions, ties, unused command, clear
        send_item(mk_item(CMD_QUERY, 0, 0, 0, 0, 0, 0), pick_gap(0));
        send_item(mk_item(CMD_UNUSED, -32768, 32767, 255, 1, 255, 1), pick_gap(0));
        send_item(mk_item(CMD_ADD, 0, 0, 0, 0, 0, 0), pick_gap(0));
        send_item(mk_item(CMD_ADD, 3, 4, 0, 0, 0, 0), pick_gap(0));
        send_item(mk_item(CMD_ADD, -3, -4, 0, 0, 0, 0), pick_gap(0));
        send_item(mk_item(CMD_ADD, 32767, -32768, 0, 0, 0, 0), pick_gap(0));
        send_item(mk_item(CMD_ADD, -32768, 32767, 0, 0, 0, 0), pick_gap(0));
        send_item(mk_item(CMD_QUERY, 0, 0, 0, 0, 0, 0), pick_gap(0));
        send_item(mk_item(CMD_QUERY, 0, 0, 0, 1, 0, 0), pick_gap(0));
        send_item(mk_item(CMD_QUERY, 0, 0, 0, 1, 1, 1), pick_gap(0));
        send_item(mk_item(CMD_QUERY, 0, 0, 1, 0, 0, 1), pick_gap(0));
        send_item(mk_item(CMD_QUERY, 0, 0, 0, 1, 0, 1), pick_gap(0));
        send_item(mk_item(CMD_QUERY, 0, 0, 200, 1, 255, 1), pick_gap(0));
        send_item(mk_item(CMD_QUERY, 32767, 32767, 255, 0, 255, 0), pick_gap(0));
        send_item(mk_item(CMD_QUERY, 32767, -32768, 0, 0, 0, 0), pick_gap(0));
        send_item(mk_item(CMD_ADD, 3, 4, 0, 0, 0, 0), pick_gap(0));
        send_item(mk_item(CMD_QUERY, 3, 4, 0, 0, 0, 0), pick_gap(0));
        send_item(mk_item(CMD_QUERY, 3, 4, 5, 1, 0, 0), pick_gap(0));
        send_item(mk_item(CMD_QUERY, 3, 4, 0, 0, 1, 1), pick_gap(0));
        send_item(mk_item(CMD_CLEAR, 1234, -1234, 7, 1, 9, 1), pick_gap(0));
        send_item(mk_item(CMD_QUERY, 0, 0, 0, 0, 0, 0), pick_gap(0));
        send_item(mk_item(CMD_ADD, -1, -1, 0, 0, 0, 0), pick_gap(0));
        send_item(mk_item(CMD_QUERY, -1, -1, 1, 1, 0, 0), pick_gap(0));
        drain_results(4);

        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            write_radius(radius_for(phase));
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS && items_sent < ITEM_TARGET) begin
                run_episode(phase == 0 && items_sent == phase_start);
            end
            drain_results(4);
            phase++;
        end
        repeat (16) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: nearest_site_search_unit.f
src/nss_pkg.sv
src/nss_site_mem.sv
src/nss_dist_unit.sv
src/nearest_site_search_unit.sv
verif/nss_result_checker.sv
verif/nearest_site_search_unit_tb.sv
